@@ rtl/ftq_pkg.sv @@
package ftq_pkg;

   localparam logic [2:0] ACT_TICK     = 3'd0;
   localparam logic [2:0] ACT_FLUSH    = 3'd1;
   localparam logic [2:0] ACT_REDIRECT = 3'd2;
   localparam logic [2:0] ACT_RETIRE   = 3'd3;
   localparam logic [2:0] ACT_SQUASH   = 3'd4;
   localparam logic [2:0] ACT_ALLOC    = 3'd5;
   localparam logic [2:0] ACT_READ     = 3'd6;

   localparam logic [2:0] RES_NONE     = 3'd0;
   localparam logic [2:0] RES_OK       = 3'd1;
   localparam logic [2:0] RES_REJECT   = 3'd2;
   localparam logic [2:0] RES_BAD_MASK = 3'd3;
   localparam logic [2:0] RES_EMPTY    = 3'd4;

   typedef struct packed {
      logic [31:0] tag;
      logic [63:0] pc;
      logic [63:0] target;
      logic [5:0]  bits;
      logic [47:0] metadata;
      logic [1:0]  packet_lanes;
   } ftq_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DONE
   } ftq_state_type;

endpackage

@@ rtl/fetch_target_queue.sv @@
// Fetch target queue: one request in flight at a time.
// Steps: the payload memory read, then the queue state update, then the
// response; no new request is accepted while one is in flight, since
// the input waits until the response has been taken.
// Reset (synchronous): all slots invalid, head, tail and count zero, next
// generation tag one; payload memory is not cleared.
module fetch_target_queue #(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [4:0]  req_entry_index,
   input  logic [31:0] req_tag_generation,
   input  logic        req_lane,
   input  logic [7:0]  req_lane_mask,
   input  logic [63:0] req_base_pc,
   input  logic [63:0] req_predicted_target,
   input  logic [2:0]  req_prediction_flags,
   input  logic [2:0]  req_cfi_info,
   input  logic [15:0] req_metadata_index,
   input  logic [31:0] req_predictor_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_code,
   output logic        rsp_reclaimed,
   output logic [4:0]  rsp_reclaimed_index,
   output logic [4:0]  rsp_slot_index,
   output logic [31:0] rsp_slot_generation,
   output logic [4:0]  rsp_head_position,
   output logic [4:0]  rsp_tail_position,
   output logic [5:0]  rsp_occupancy,
   output logic [63:0] rsp_read_pc,
   output logic [63:0] rsp_read_target,
   output logic [9:0]  rsp_read_control,
   output logic [47:0] rsp_read_metadata
);
   import ftq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
   localparam logic [IW:0] DEPTH_W = (IW + 1)'(DEPTH);

   ftq_state_type state_ff, state_in;

   logic [2:0]  act_ff;
   logic [4:0]  eidx_ff;
   logic [31:0] tagg_ff;
   logic        lane_ff;
   logic [7:0]  lmask_ff;
   logic [63:0] pc_ff, tgt_ff;
   logic [2:0]  flags_ff, cfi_ff;
   logic [15:0] meta_ff;
   logic [31:0] ptag_ff;

   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [1:0]       live_ff [DEPTH];
   logic [1:0]       live_in [DEPTH];
   logic [IW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [31:0]      ntag_ff, ntag_in;

   logic [2:0]  code_ff, code_in;
   logic        rec_ff, rec_in;
   logic [4:0]  rec_idx_ff, rec_idx_in, sidx_ff, sidx_in;
   logic [31:0] stag_ff, stag_in;
   logic [63:0] rpc_ff, rpc_in, rtgt_ff, rtgt_in;
   logic [9:0]  rctl_ff, rctl_in;
   logic [47:0] rmeta_ff, rmeta_in;

   logic          accept, look, wr_en;
   ftq_entry_type rd, wr_data;

   assign accept = req_valid && req_ready;
   assign look   = (state_ff == ST_LOOK);

   ftq_store #(.DEPTH(DEPTH), .IW(IW)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data(wr_data),
      .rd_addr(IW'(req_entry_index)),
      .rd_data(rd)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_LOOK;
         ST_LOOK: state_in = ST_DONE;
         ST_DONE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
   end

   always_comb begin
      logic [IW-1:0] idx, t, k_i;
      logic          in_range, active, hit, ok;
      logic [IW:0]   span, off;
      logic [1:0]    m, bitm;
      logic          pv, tk, tv;
      int            k;
      hit      = 1'b0;
      ok       = 1'b0;
      off      = '0;
      k_i      = '0;
      idx      = IW'(eidx_ff);
      in_range = ({27'd0, eidx_ff} < 32'(DEPTH));
      active   = in_range && valid_ff[idx] && (rd.tag == tagg_ff);
      valid_in = valid_ff;
      for (k = 0; k < DEPTH; k++) live_in[k] = live_ff[k];
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      ntag_in = ntag_ff;
      code_in = RES_NONE;
      rec_in = 1'b0;
      rec_idx_in = '0;
      sidx_in = '0;
      stag_in = '0;
      rpc_in = '0;
      rtgt_in = '0;
      rctl_in = '0;
      rmeta_in = '0;
      wr_en = 1'b0;
      m = lmask_ff[1:0];
      pv = flags_ff[0];
      tk = pv & flags_ff[1];
      tv = pv & flags_ff[2];
      t = tail_ff;
      wr_data.tag = ntag_ff;
      wr_data.pc = pc_ff;
      wr_data.target = tv ? tgt_ff : 64'd0;
      wr_data.bits = {cfi_ff[2:1], cfi_ff[0], tv, tk, pv};
      wr_data.metadata = {ptag_ff, meta_ff};
      wr_data.packet_lanes = m;
      span = {1'b0, idx} - {1'b0, head_ff};
      if ({1'b0, idx} < {1'b0, head_ff}) span = span + DEPTH_W;
      bitm = lane_ff ? 2'b10 : 2'b01;
      if (act_ff == ACT_FLUSH) begin
         valid_in = '0;
         for (k = 0; k < DEPTH; k++) live_in[k] = 2'b00;
         head_in = '0;
         tail_in = '0;
         count_in = '0;
         ntag_in = (ntag_ff + 32'd1 == 32'd0) ? 32'd1 : ntag_ff + 32'd1;
      end else begin
         case (act_ff)
            ACT_REDIRECT: begin
               code_in = RES_REJECT;
               if (active && ((IW + 1 >= CW) ? (CW'(span) < count_ff)
                                              : ((CW + 1)'(span) < (CW + 1)'(count_ff)))) begin
                  for (k = 0; k < DEPTH; k++) begin
                     k_i = IW'(k);
                     off = {1'b0, k_i} - {1'b0, head_ff};
                     if ({1'b0, k_i} < {1'b0, head_ff}) off = off + DEPTH_W;
                     if (off > span && CW'(off) < count_ff) begin
                        valid_in[k] = 1'b0;
                        live_in[k] = 2'b00;
                     end
                  end
                  live_in[idx] = live_ff[idx] & m & rd.packet_lanes;
                  tail_in = (idx == LAST) ? '0 : idx + 1'b1;
                  count_in = CW'(span) + 1'b1;
                  code_in = RES_OK;
               end
            end
            ACT_RETIRE, ACT_SQUASH: begin
               ok = active && ((rd.packet_lanes & bitm) != 2'b00)
                    && ((live_ff[idx] & bitm) != 2'b00);
               if (ok) live_in[idx] = live_ff[idx] & ~bitm;
               code_in = ok ? RES_OK : RES_REJECT;
            end
            default: code_in = RES_NONE;
         endcase
         if (count_in != '0 && valid_in[head_in] && live_in[head_in] == 2'b00) begin
            rec_in = 1'b1;
            rec_idx_in = 5'(head_in);
            valid_in[head_in] = 1'b0;
            head_in = (head_in == LAST) ? '0 : head_in + 1'b1;
            count_in = count_in - 1'b1;
         end
         case (act_ff)
            ACT_ALLOC: begin
               t = tail_in;
               if (lmask_ff[7:2] != 6'd0 || m == 2'b10) begin
                  code_in = RES_BAD_MASK;
               end else if (m == 2'b00) begin
                  code_in = RES_EMPTY;
               end else if (count_in >= CW'(DEPTH)) begin
                  code_in = RES_REJECT;
               end else begin
                  wr_en = look;
                  valid_in[t] = 1'b1;
                  live_in[t] = m;
                  sidx_in = 5'(t);
                  stag_in = ntag_ff;
                  ntag_in = (ntag_ff + 32'd1 == 32'd0) ? 32'd1 : ntag_ff + 32'd1;
                  tail_in = (t == LAST) ? '0 : t + 1'b1;
                  count_in = count_in + 1'b1;
                  code_in = RES_OK;
               end
            end
            ACT_READ: begin
               hit = in_range && valid_in[idx] && (rd.tag == tagg_ff);
               if (hit) begin
                  code_in = RES_OK;
                  rpc_in = rd.pc;
                  rtgt_in = rd.target;
                  rctl_in = {rd.bits, live_in[idx], rd.packet_lanes};
                  rmeta_in = rd.metadata;
               end else begin
                  code_in = RES_REJECT;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         for (int k = 0; k < DEPTH; k++) live_ff[k] <= 2'b00;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         ntag_ff <= 32'd1;
      end else begin
         state_ff <= state_in;
         if (look) begin
            valid_ff <= valid_in;
            for (int k = 0; k < DEPTH; k++) live_ff[k] <= live_in[k];
            head_ff <= head_in;
            tail_ff <= tail_in;
            count_ff <= count_in;
            ntag_ff <= ntag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         eidx_ff <= req_entry_index;
         tagg_ff <= req_tag_generation;
         lane_ff <= req_lane;
         lmask_ff <= req_lane_mask;
         pc_ff <= req_base_pc;
         tgt_ff <= req_predicted_target;
         flags_ff <= req_prediction_flags;
         cfi_ff <= req_cfi_info;
         meta_ff <= req_metadata_index;
         ptag_ff <= req_predictor_tag;
      end
      if (look) begin
         code_ff <= code_in;
         rec_ff <= rec_in;
         rec_idx_ff <= rec_idx_in;
         sidx_ff <= sidx_in;
         stag_ff <= stag_in;
         rpc_ff <= rpc_in;
         rtgt_ff <= rtgt_in;
         rctl_ff <= rctl_in;
         rmeta_ff <= rmeta_in;
      end
   end

   assign rsp_result_code     = code_ff;
   assign rsp_reclaimed       = rec_ff;
   assign rsp_reclaimed_index = rec_idx_ff;
   assign rsp_slot_index      = sidx_ff;
   assign rsp_slot_generation = stag_ff;
   assign rsp_head_position   = 5'(head_ff);
   assign rsp_tail_position   = 5'(tail_ff);
   assign rsp_occupancy       = 6'(count_ff);
   assign rsp_read_pc         = rpc_ff;
   assign rsp_read_target     = rtgt_ff;
   assign rsp_read_control    = rctl_ff;
   assign rsp_read_metadata   = rmeta_ff;

endmodule

@@ rtl/ftq_store.sv @@
module ftq_store #(
   parameter int DEPTH = 32,
   parameter int IW = 5
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IW-1:0]         wr_addr,
   input  ftq_pkg::ftq_entry_type wr_data,
   input  logic [IW-1:0]         rd_addr,
   output ftq_pkg::ftq_entry_type rd_data
);
   import ftq_pkg::*;

   ftq_entry_type mem [DEPTH];
   ftq_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
